// ===== rtl/xdp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the XML declaration parser.
// No dependencies; used by xdp_core, xdp_fifo and the top level.
package xdp_pkg;

    // Default width of the internal byte counter
    localparam int LENGTH_BITS_DEF = 16;

    // Result queue depth and pointer width
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Result kinds
    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SPACE      = 3'd1;
    localparam logic [2:0] ST_VERSION    = 3'd2;
    localparam logic [2:0] ST_ENCODING   = 3'd3;
    localparam logic [2:0] ST_STANDALONE = 3'd4;
    localparam logic [2:0] ST_UNFINISHED = 3'd5;

    // Standalone codes (two's complement: 1 yes, 0 no, -1 absent)
    localparam logic [1:0] SA_YES    = 2'b01;
    localparam logic [1:0] SA_NO     = 2'b00;
    localparam logic [1:0] SA_ABSENT = 2'b11;

    // One result item as it leaves the block
    typedef struct packed {
        logic        kind;
        logic [7:0]  name;
        logic [2:0]  status;
        logic [15:0] len;
        logic [1:0]  sa;
        logic        enc;
        logic        run_end;
    } t_out;

    // Result slot handed from the parser to the queue
    typedef struct packed {
        logic valid;
        t_out item;
    } t_slot;

endpackage

// ===== rtl/xdp_core.sv =====
`timescale 1ns / 1ps
// Parser state machine: consumes one byte per transfer, plus the end mark,
// and produces up to two result slots. Depends on xdp_pkg.
module xdp_core #(
    parameter int LENGTH_BITS = xdp_pkg::LENGTH_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_data_byte,
    input  logic          i_is_first,
    input  logic          i_is_last,
    output xdp_pkg::t_slot o_slot0,
    output xdp_pkg::t_slot o_slot1
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_PREFIX, PH_VER_SPACE, PH_VER_KW, PH_VER_EQ, PH_VER_Q,
        PH_VER_VAL, PH_AFT_VER, PH_ENC_KW, PH_ENC_EQ, PH_ENC_Q, PH_ENC_NAME,
        PH_AFT_ENC, PH_SA_KW, PH_SA_EQ, PH_SA_Q, PH_SA_VAL, PH_AFT_SA, PH_CLOSE
    } t_phase;

    typedef enum logic [2:0] {
        W_OPEN, W_VERSION, W_ONE, W_ENC, W_SA, W_YES, W_NO
    } t_word;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  kidx;
        logic [7:0]  quote;
        logic        blank;
        logic [1:0]  sa;
        logic        enc;
        logic        done;
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name;
        logic [2:0]  status;
        logic [1:0]  sa;
        logic        enc;
        logic        use_cnt;
    } t_res;

    typedef struct packed {
        t_state st;
        logic   hit;
        t_res   res;
    } t_feed;

    localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return c == 8'h27 || c == 8'h22;
    endfunction

    function automatic logic [3:0] word_len(input t_word w);
        logic [3:0] n;
        unique case (w)
            W_OPEN:    n = 4'd5;
            W_VERSION: n = 4'd7;
            W_ONE:     n = 4'd3;
            W_ENC:     n = 4'd8;
            W_SA:      n = 4'd10;
            W_YES:     n = 4'd3;
            W_NO:      n = 4'd2;
            default:   n = 4'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] word_char(input t_word w, input logic [3:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (w)
            W_OPEN: begin
                case (i)
                    4'd0: ch = "<";  4'd1: ch = "?";  4'd2: ch = "x";
                    4'd3: ch = "m";  4'd4: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
            W_VERSION: begin
                case (i)
                    4'd0: ch = "v";  4'd1: ch = "e";  4'd2: ch = "r";  4'd3: ch = "s";
                    4'd4: ch = "i";  4'd5: ch = "o";  4'd6: ch = "n";
                    default: ch = 8'h00;
                endcase
            end
            W_ONE: begin
                case (i)
                    4'd0: ch = "1";  4'd1: ch = ".";  4'd2: ch = "0";
                    default: ch = 8'h00;
                endcase
            end
            W_ENC: begin
                case (i)
                    4'd0: ch = "e";  4'd1: ch = "n";  4'd2: ch = "c";  4'd3: ch = "o";
                    4'd4: ch = "d";  4'd5: ch = "i";  4'd6: ch = "n";  4'd7: ch = "g";
                    default: ch = 8'h00;
                endcase
            end
            W_SA: begin
                case (i)
                    4'd0: ch = "s";  4'd1: ch = "t";  4'd2: ch = "a";  4'd3: ch = "n";
                    4'd4: ch = "d";  4'd5: ch = "a";  4'd6: ch = "l";  4'd7: ch = "o";
                    4'd8: ch = "n";  4'd9: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            W_YES: begin
                case (i)
                    4'd0: ch = "y";  4'd1: ch = "e";  4'd2: ch = "s";
                    default: ch = 8'h00;
                endcase
            end
            W_NO: begin
                case (i)
                    4'd0: ch = "n";  4'd1: ch = "o";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic word_hit(input t_word w, input logic [3:0] i,
                                      input logic [7:0] c);
        return (i < word_len(w)) && (word_char(w, i) == c);
    endfunction

    function automatic t_feed give_fail(input t_feed f, input logic [2:0] st);
        t_feed g;
        g = f;
        g.hit        = 1'b1;
        g.res        = '0;
        g.res.kind   = xdp_pkg::KIND_VERDICT;
        g.res.status = st;
        g.res.sa     = xdp_pkg::SA_ABSENT;
        g.st.done    = 1'b1;
        return g;
    endfunction

    function automatic t_feed give_ok(input t_feed f, input logic [1:0] sa,
                                      input logic enc, input logic use_cnt);
        t_feed g;
        g = f;
        g.hit         = 1'b1;
        g.res         = '0;
        g.res.kind    = xdp_pkg::KIND_VERDICT;
        g.res.status  = xdp_pkg::ST_OK;
        g.res.sa      = sa;
        g.res.enc     = enc;
        g.res.use_cnt = use_cnt;
        g.st.done     = 1'b1;
        return g;
    endfunction

    // One state transition for one byte
    function automatic t_feed feed(input t_state s, input logic [7:0] c);
        t_feed      f;
        logic [3:0] k1;
        t_word      w;
        f     = '0;
        f.st  = s;
        k1    = s.kidx + 4'd1;
        w     = W_ENC;
        unique case (s.phase)
            PH_PREFIX: begin
                if (!word_hit(W_OPEN, s.kidx, c)) begin
                    f = give_ok(f, xdp_pkg::SA_ABSENT, 1'b0, 1'b0);
                end else begin
                    f.st.kidx = k1;
                    if (k1 == word_len(W_OPEN)) f.st.phase = PH_VER_SPACE;
                end
            end
            PH_VER_SPACE: begin
                if (!is_blank(c)) begin
                    f = give_fail(f, xdp_pkg::ST_SPACE);
                end else begin
                    f.st.phase = PH_VER_KW;
                    f.st.kidx  = 4'd0;
                end
            end
            PH_VER_KW: begin
                if (!(s.kidx == 4'd0 && is_blank(c))) begin
                    if (!word_hit(W_VERSION, s.kidx, c)) begin
                        f = give_fail(f, xdp_pkg::ST_VERSION);
                    end else begin
                        f.st.kidx = k1;
                        if (k1 == word_len(W_VERSION)) f.st.phase = PH_VER_EQ;
                    end
                end
            end
            PH_VER_EQ, PH_ENC_EQ, PH_SA_EQ: begin
                if (!is_blank(c)) begin
                    if (c != "=") begin
                        if (s.phase == PH_VER_EQ)      f = give_fail(f, xdp_pkg::ST_VERSION);
                        else if (s.phase == PH_ENC_EQ) f = give_fail(f, xdp_pkg::ST_ENCODING);
                        else                           f = give_fail(f, xdp_pkg::ST_STANDALONE);
                    end else begin
                        if (s.phase == PH_VER_EQ)      f.st.phase = PH_VER_Q;
                        else if (s.phase == PH_ENC_EQ) f.st.phase = PH_ENC_Q;
                        else                           f.st.phase = PH_SA_Q;
                    end
                end
            end
            PH_VER_Q, PH_ENC_Q, PH_SA_Q: begin
                if (!is_blank(c)) begin
                    if (!is_quote(c)) begin
                        if (s.phase == PH_VER_Q)      f = give_fail(f, xdp_pkg::ST_VERSION);
                        else if (s.phase == PH_ENC_Q) f = give_fail(f, xdp_pkg::ST_ENCODING);
                        else                          f = give_fail(f, xdp_pkg::ST_STANDALONE);
                    end else begin
                        f.st.quote = c;
                        f.st.kidx  = 4'd0;
                        if (s.phase == PH_VER_Q)      f.st.phase = PH_VER_VAL;
                        else if (s.phase == PH_ENC_Q) f.st.phase = PH_ENC_NAME;
                        else                          f.st.phase = PH_SA_VAL;
                    end
                end
            end
            PH_VER_VAL: begin
                if (s.kidx < word_len(W_ONE)) begin
                    if (!word_hit(W_ONE, s.kidx, c)) f = give_fail(f, xdp_pkg::ST_VERSION);
                    else                             f.st.kidx = k1;
                end else if (c != s.quote) begin
                    f = give_fail(f, xdp_pkg::ST_VERSION);
                end else begin
                    f.st.blank = 1'b0;
                    f.st.phase = PH_AFT_VER;
                end
            end
            PH_AFT_VER, PH_AFT_ENC: begin
                if (is_blank(c)) begin
                    f.st.blank = 1'b1;
                end else if (c == "e" && s.phase == PH_AFT_VER) begin
                    f.st.phase = PH_ENC_KW;
                    f.st.kidx  = 4'd1;
                end else if (c == "s") begin
                    f.st.phase = PH_SA_KW;
                    f.st.kidx  = 4'd1;
                end else if (c == "?") begin
                    f.st.phase = PH_CLOSE;
                end else begin
                    f = give_fail(f, xdp_pkg::ST_UNFINISHED);
                end
            end
            PH_ENC_KW, PH_SA_KW: begin
                w = (s.phase == PH_ENC_KW) ? W_ENC : W_SA;
                if (!word_hit(w, s.kidx, c)) begin
                    f = give_fail(f, xdp_pkg::ST_UNFINISHED);
                end else begin
                    f.st.kidx = k1;
                    if (k1 == word_len(w)) begin
                        if (!s.blank)              f = give_fail(f, xdp_pkg::ST_SPACE);
                        else if (w == W_ENC)       f.st.phase = PH_ENC_EQ;
                        else                       f.st.phase = PH_SA_EQ;
                    end
                end
            end
            PH_ENC_NAME: begin
                if (c == s.quote) begin
                    f.st.enc   = 1'b1;
                    f.st.blank = 1'b0;
                    f.st.phase = PH_AFT_ENC;
                end else if (c == 8'h00) begin
                    f = give_fail(f, xdp_pkg::ST_ENCODING);
                end else begin
                    f.hit      = 1'b1;
                    f.res      = '0;
                    f.res.kind = xdp_pkg::KIND_NAME;
                    f.res.name = c;
                end
            end
            PH_SA_VAL: begin
                w = (s.sa == xdp_pkg::SA_YES) ? W_YES : W_NO;
                if (s.kidx == 4'd0) begin
                    f.st.kidx = 4'd1;
                    if (c == "y")      f.st.sa = xdp_pkg::SA_YES;
                    else if (c == "n") f.st.sa = xdp_pkg::SA_NO;
                    else               f = give_fail(f, xdp_pkg::ST_STANDALONE);
                end else if (s.kidx < word_len(w)) begin
                    if (!word_hit(w, s.kidx, c)) f = give_fail(f, xdp_pkg::ST_STANDALONE);
                    else                         f.st.kidx = k1;
                end else if (c != s.quote) begin
                    f = give_fail(f, xdp_pkg::ST_STANDALONE);
                end else begin
                    f.st.phase = PH_AFT_SA;
                end
            end
            PH_AFT_SA: begin
                if (!is_blank(c)) begin
                    if (c != "?") f = give_fail(f, xdp_pkg::ST_UNFINISHED);
                    else          f.st.phase = PH_CLOSE;
                end
            end
            PH_CLOSE: begin
                if (c != ">") f = give_fail(f, xdp_pkg::ST_UNFINISHED);
                else          f = give_ok(f, s.sa, s.enc, 1'b1);
            end
            default: f = give_fail(f, xdp_pkg::ST_UNFINISHED);
        endcase
        return f;
    endfunction

    function automatic xdp_pkg::t_out to_out(input t_res r, input logic [15:0] len,
                                             input logic last);
        xdp_pkg::t_out o;
        o.kind    = r.kind;
        o.name    = r.name;
        o.status  = r.status;
        o.len     = r.use_cnt ? len : 16'd0;
        o.sa      = r.sa;
        o.enc     = r.enc;
        o.run_end = last;
        return o;
    endfunction

    t_state                 r_state, n_state, s0;
    logic [LENGTH_BITS-1:0] r_cnt, n_cnt, cnt0, cnt1;
    logic [CW-1:0]          cnt_ext;
    logic [15:0]            len16;
    t_feed                  f1, f2;
    logic                   active, use2;

    // Pick the starting state, run the byte and then the end mark
    always_comb begin
        s0   = r_state;
        cnt0 = r_cnt;
        if (i_is_first) begin
            s0.phase = PH_PREFIX;
            s0.kidx  = 4'd0;
            s0.quote = 8'h00;
            s0.blank = 1'b0;
            s0.sa    = xdp_pkg::SA_ABSENT;
            s0.enc   = 1'b0;
            s0.done  = 1'b0;
            cnt0     = '0;
        end
        active  = !s0.done;
        cnt1    = (cnt0 == {LENGTH_BITS{1'b1}}) ? cnt0 : cnt0 + 1'b1;
        cnt_ext = CW'(cnt1);
        len16   = (cnt_ext > CW'(16'hFFFF)) ? 16'hFFFF : cnt_ext[15:0];
        f1      = feed(s0, i_data_byte);
        f2      = feed(f1.st, 8'h00);
        use2    = active && i_is_last && !f1.st.done;
        n_state = active ? (use2 ? f2.st : f1.st) : s0;
        n_cnt   = active ? cnt1 : cnt0;

        o_slot1.valid = use2 && f2.hit;
        o_slot1.item  = to_out(f2.res, len16, 1'b1);
        o_slot0.valid = active && f1.hit;
        o_slot0.item  = to_out(f1.res, len16, !o_slot1.valid);
    end

    // Hold parser state; advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= PH_IDLE;
            r_state.kidx  <= 4'd0;
            r_state.quote <= 8'h00;
            r_state.blank <= 1'b0;
            r_state.sa    <= xdp_pkg::SA_ABSENT;
            r_state.enc   <= 1'b0;
            r_state.done  <= 1'b1;
            r_cnt         <= '0;
        end else if (i_take) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== rtl/xdp_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, gives one per transfer.
// Depends on xdp_pkg.
module xdp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  xdp_pkg::t_slot i_slot0,
    input  xdp_pkg::t_slot i_slot1,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_stall,
    output xdp_pkg::t_out  o_item
);

    localparam int PW = xdp_pkg::QPTR_W;
    localparam int CNW = xdp_pkg::QCNT_W;

    xdp_pkg::t_out  mem [xdp_pkg::QDEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CNW-1:0] r_cnt;
    logic [1:0]     n_push;
    logic           pop;
    xdp_pkg::t_out  first_item;

    // Compact the two slots; count pushes and pops
    always_comb begin
        first_item = i_slot0.valid ? i_slot0.item : i_slot1.item;
        n_push     = i_push ? (2'(i_slot0.valid) + 2'(i_slot1.valid)) : 2'd0;
        pop        = o_valid && !i_stall;
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt > CNW'(xdp_pkg::QDEPTH - 2));
    assign o_item  = mem[r_rd];

    // Write entries
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) mem[r_wr] <= first_item;
        if (n_push == 2'd2) mem[r_wr + 1'b1] <= i_slot1.item;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PW'(n_push);
            r_rd  <= r_rd + PW'(pop);
            r_cnt <= r_cnt + CNW'(n_push) - CNW'(pop);
        end
    end

endmodule

// ===== rtl/xml_declaration_parser_top.sv =====
`timescale 1ns / 1ps
// XML declaration parser top level: parser state machine plus result queue.
// Depends on xdp_pkg, xdp_core and xdp_fifo.
// Results are registered in the queue as their byte is taken.
// One byte per cycle while o_stall is low; one result leaves per cycle unless
// i_stall is high; a byte may cause two results (name byte plus end verdict).
// Reset (synchronous, active low) empties the queue and idles until a first mark.
module xml_declaration_parser_top #(
    parameter int LENGTH_BITS = xdp_pkg::LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_is_first,
    input  logic              i_is_last,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_item_kind,
    output logic [7:0]        o_name_byte,
    output logic [2:0]        o_status,
    output logic [15:0]       o_decl_length,
    output logic signed [1:0] o_standalone_value,
    output logic              o_encoding_present,
    output logic              o_run_end
);

    xdp_pkg::t_slot slot0, slot1;
    xdp_pkg::t_out  item;
    logic           full, take;

    // Accept a byte whenever the queue has room for two results
    assign o_stall = full;
    assign take    = i_valid && !full;

    xdp_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_data_byte),
        .i_is_first  (i_is_first),
        .i_is_last   (i_is_last),
        .o_slot0     (slot0),
        .o_slot1     (slot1)
    );

    xdp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_slot0 (slot0),
        .i_slot1 (slot1),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (item)
    );

    // Unpack the head result onto the ports
    assign o_item_kind        = item.kind;
    assign o_name_byte        = item.name;
    assign o_status           = item.status;
    assign o_decl_length      = item.len;
    assign o_standalone_value = $signed(item.sa);
    assign o_encoding_present = item.enc;
    assign o_run_end          = item.run_end;

endmodule

// ===== verif/xml_declaration_parser_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for xml_declaration_parser_top: directed texts, then random
// well-formed and broken declarations. Depends on xdp_pkg and the top level only.
module xml_declaration_parser_top_test;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int ITEM_COUNT   = 1450;
    localparam int DRAIN_CYCLES = 12;
    localparam int SQUEEZE_LEN  = 400;
    localparam int N_ROWS       = 21;

    // Characters the parser reacts to
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_SQ   = 8'h27;
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_QM   = 8'h3F;
    localparam logic [7:0] CH_LC_E = 8'h65;
    localparam logic [7:0] CH_LC_N = 8'h6E;
    localparam logic [7:0] CH_LC_S = 8'h73;
    localparam logic [7:0] CH_LC_Y = 8'h79;

    localparam string KW_OPEN       = "<?xml";
    localparam string KW_VERSION    = "version";
    localparam string KW_ONE        = "1.0";
    localparam string KW_ENCODING   = "encoding";
    localparam string KW_STANDALONE = "standalone";
    localparam string KW_YES        = "yes";
    localparam string KW_NO         = "no";
    localparam string NAME_CHARS    =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_.";

    typedef enum logic [5:0] {
        P_IDLE, P_PREFIX, P_VER_SPACE, P_VER_KW, P_VER_EQ, P_VER_Q, P_VER_VAL,
        P_AFT_VER, P_ENC_KW, P_ENC_EQ, P_ENC_Q, P_ENC_NAME, P_AFT_ENC,
        P_SA_KW, P_SA_EQ, P_SA_Q, P_SA_VAL, P_AFT_SA, P_CLOSE
    } t_parse_phase;

    // One directed text: head, a run of spaces, tail; optional zero byte at zpos
    typedef struct {
        string       head;
        int          pad;
        string       tail;
        int          zpos;
        bit          first;
        bit          last;
        bit          typed;
        logic [2:0]  st;
        logic [15:0] len;
        logic [1:0]  sa;
        bit          enc;
    } t_text_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_data_byte;
    logic              i_is_first;
    logic              i_is_last;
    logic              o_valid;
    logic              i_stall;
    logic              o_item_kind;
    logic [7:0]        o_name_byte;
    logic [2:0]        o_status;
    logic [15:0]       o_decl_length;
    logic signed [1:0] o_standalone_value;
    logic              o_encoding_present;
    logic              o_run_end;

    xml_declaration_parser_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .i_is_first         (i_is_first),
        .i_is_last          (i_is_last),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_item_kind        (o_item_kind),
        .o_name_byte        (o_name_byte),
        .o_status           (o_status),
        .o_decl_length      (o_decl_length),
        .o_standalone_value (o_standalone_value),
        .o_encoding_present (o_encoding_present),
        .o_run_end          (o_run_end)
    );

    // Parser copy kept by the bench
    t_parse_phase ps_phase;
    logic [3:0]   ps_kidx;
    logic [7:0]   ps_quote;
    logic         ps_blank;
    logic [15:0]  ps_count;
    logic [1:0]   ps_sa;
    logic         ps_enc;
    logic         ps_done;

    xdp_pkg::t_out step_out[$];
    xdp_pkg::t_out pending_results[$];
    logic [7:0]    text_q[$];

    int errors = 0;
    int cycles = 0;
    int sent_bytes;
    bit quiet;
    bit squeeze_req;

    t_text_row text_rows [N_ROWS] = '{
        '{"<?xml", 0, "", -1, 1'b0, 1'b1, 1'b0,
          xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"abc", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?x", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"Q<?xml", 0, "", 0, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version='1.0'?>", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_OK, 16'd21, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version=\"1.0\" encoding='UTF-8' standalone='yes' ?>", 0, "", -1,
          1'b1, 1'b1, 1'b0, xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xmlversion='1.0'?>", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_SPACE, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml versiom='1.0'?>", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_VERSION, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version = \"1.0'?>", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_VERSION, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version='1.0' encoding='A\377Bz'?>", 0, "", 33, 1'b1, 1'b1, 1'b0,
          xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version='1.0'encoding='x'?>", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_SPACE, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version='1.0' standalone='maybe'?>", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_STANDALONE, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version='1.0' encoding='a' encoding='b'?>", 0, "", -1,
          1'b1, 1'b1, 1'b0, xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version='1.0' encodinx", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_UNFINISHED, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml ver", 0, "", -1, 1'b1, 1'b0, 1'b0,
          xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml\tversion\n=\r'1.0' standalone = \"no\"\t?>junk", 0, "", -1,
          1'b1, 1'b1, 1'b0, xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version='1.0'\r\n?", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_UNFINISHED, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version='1.0' encoding=\"\"?>", 0, "", -1, 1'b1, 1'b1, 1'b0,
          xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version='1.0'", 100, "?>", -1, 1'b1, 1'b1, 1'b0,
          xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0},
        '{"<?xml version='1.0' standalone='yes'?>", 0, "", -1, 1'b1, 1'b1, 1'b1,
          xdp_pkg::ST_OK, 16'd38, xdp_pkg::SA_YES, 1'b0}
    };

    // ---------------------------------------------------------------- parser copy

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic bit kw_match(input string w, input logic [7:0] c);
        if (int'(ps_kidx) < w.len() && w[ps_kidx] == c) begin
            ps_kidx++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void give_verdict(input logic [2:0] st, input logic [15:0] len,
                                         input logic [1:0] sa, input logic en);
        xdp_pkg::t_out v;
        v = '0;
        v.kind   = xdp_pkg::KIND_VERDICT;
        v.status = st;
        v.len    = len;
        v.sa     = sa;
        v.enc    = en;
        ps_done  = 1'b1;
        step_out.push_back(v);
    endfunction

    function automatic void give_error(input logic [2:0] st);
        give_verdict(st, 16'd0, xdp_pkg::SA_ABSENT, 1'b0);
    endfunction

    // Status for a bad '=' or quote, by the attribute being parsed
    function automatic logic [2:0] attr_status(input t_parse_phase ph);
        case (ph)
            P_VER_EQ, P_VER_Q: return xdp_pkg::ST_VERSION;
            P_ENC_EQ, P_ENC_Q: return xdp_pkg::ST_ENCODING;
            default:           return xdp_pkg::ST_STANDALONE;
        endcase
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        xdp_pkg::t_out nb;
        int            kw_len;
        case (ps_phase)
            P_PREFIX: begin
                if (!kw_match(KW_OPEN, c))
                    give_verdict(xdp_pkg::ST_OK, 16'd0, xdp_pkg::SA_ABSENT, 1'b0);
                else if (ps_kidx == 4'd5)
                    ps_phase = P_VER_SPACE;
            end
            P_VER_SPACE: begin
                if (!is_blank(c)) begin
                    give_error(xdp_pkg::ST_SPACE);
                end else begin
                    ps_phase = P_VER_KW;
                    ps_kidx  = '0;
                end
            end
            P_VER_KW: begin
                if (!(ps_kidx == 4'd0 && is_blank(c))) begin
                    if (!kw_match(KW_VERSION, c))
                        give_error(xdp_pkg::ST_VERSION);
                    else if (ps_kidx == 4'd7)
                        ps_phase = P_VER_EQ;
                end
            end
            P_VER_EQ, P_ENC_EQ, P_SA_EQ: begin
                if (!is_blank(c)) begin
                    if (c != CH_EQ)
                        give_error(attr_status(ps_phase));
                    else if (ps_phase == P_VER_EQ)
                        ps_phase = P_VER_Q;
                    else if (ps_phase == P_ENC_EQ)
                        ps_phase = P_ENC_Q;
                    else
                        ps_phase = P_SA_Q;
                end
            end
            P_VER_Q, P_ENC_Q, P_SA_Q: begin
                if (!is_blank(c)) begin
                    if (c != CH_SQ && c != CH_DQ) begin
                        give_error(attr_status(ps_phase));
                    end else begin
                        ps_quote = c;
                        ps_kidx  = '0;
                        if (ps_phase == P_VER_Q)
                            ps_phase = P_VER_VAL;
                        else if (ps_phase == P_ENC_Q)
                            ps_phase = P_ENC_NAME;
                        else
                            ps_phase = P_SA_VAL;
                    end
                end
            end
            P_VER_VAL: begin
                if (ps_kidx < 4'd3) begin
                    if (!kw_match(KW_ONE, c))
                        give_error(xdp_pkg::ST_VERSION);
                end else if (c != ps_quote) begin
                    give_error(xdp_pkg::ST_VERSION);
                end else begin
                    ps_blank = 1'b0;
                    ps_phase = P_AFT_VER;
                end
            end
            P_AFT_VER, P_AFT_ENC: begin
                if (is_blank(c)) begin
                    ps_blank = 1'b1;
                end else if (c == CH_LC_E && ps_phase == P_AFT_VER) begin
                    ps_phase = P_ENC_KW;
                    ps_kidx  = 4'd1;
                end else if (c == CH_LC_S) begin
                    ps_phase = P_SA_KW;
                    ps_kidx  = 4'd1;
                end else if (c == CH_QM) begin
                    ps_phase = P_CLOSE;
                end else begin
                    give_error(xdp_pkg::ST_UNFINISHED);
                end
            end
            P_ENC_KW, P_SA_KW: begin
                kw_len = (ps_phase == P_ENC_KW) ? 8 : 10;
                if (!kw_match(ps_phase == P_ENC_KW ? KW_ENCODING : KW_STANDALONE, c))
                    give_error(xdp_pkg::ST_UNFINISHED);
                else if (int'(ps_kidx) == kw_len) begin
                    // blank before the keyword is checked only once it is complete
                    if (!ps_blank)
                        give_error(xdp_pkg::ST_SPACE);
                    else
                        ps_phase = (ps_phase == P_ENC_KW) ? P_ENC_EQ : P_SA_EQ;
                end
            end
            P_ENC_NAME: begin
                if (c == ps_quote) begin
                    ps_enc   = 1'b1;
                    ps_blank = 1'b0;
                    ps_phase = P_AFT_ENC;
                end else if (c == CH_NUL) begin
                    give_error(xdp_pkg::ST_ENCODING);
                end else begin
                    nb      = '0;
                    nb.kind = xdp_pkg::KIND_NAME;
                    nb.name = c;
                    step_out.push_back(nb);
                end
            end
            P_SA_VAL: begin
                if (ps_kidx == 4'd0) begin
                    if (c == CH_LC_Y) begin
                        ps_sa   = xdp_pkg::SA_YES;
                        ps_kidx = 4'd1;
                    end else if (c == CH_LC_N) begin
                        ps_sa   = xdp_pkg::SA_NO;
                        ps_kidx = 4'd1;
                    end else begin
                        give_error(xdp_pkg::ST_STANDALONE);
                    end
                end else begin
                    kw_len = (ps_sa == xdp_pkg::SA_YES) ? 3 : 2;
                    if (int'(ps_kidx) < kw_len) begin
                        if (!kw_match(ps_sa == xdp_pkg::SA_YES ? KW_YES : KW_NO, c))
                            give_error(xdp_pkg::ST_STANDALONE);
                    end else if (c != ps_quote) begin
                        give_error(xdp_pkg::ST_STANDALONE);
                    end else begin
                        ps_phase = P_AFT_SA;
                    end
                end
            end
            P_AFT_SA: begin
                if (!is_blank(c)) begin
                    if (c != CH_QM)
                        give_error(xdp_pkg::ST_UNFINISHED);
                    else
                        ps_phase = P_CLOSE;
                end
            end
            P_CLOSE: begin
                if (c != CH_GT)
                    give_error(xdp_pkg::ST_UNFINISHED);
                else
                    give_verdict(xdp_pkg::ST_OK, ps_count, ps_sa, ps_enc);
            end
            default: give_error(xdp_pkg::ST_UNFINISHED);
        endcase
    endfunction

    function automatic void start_text();
        ps_phase = P_PREFIX;
        ps_kidx  = '0;
        ps_quote = '0;
        ps_blank = 1'b0;
        ps_count = '0;
        ps_sa    = xdp_pkg::SA_ABSENT;
        ps_enc   = 1'b0;
        ps_done  = 1'b0;
    endfunction

    // One accepted byte: fills step_out with the results it causes
    function automatic void decl_step(input logic [7:0] c, input bit first, input bit last);
        step_out.delete();
        if (first)
            start_text();
        if (!ps_done) begin
            if (ps_count != 16'hFFFF)
                ps_count++;
            parse_char(c);
            // end of text reads as one more zero byte
            if (last && !ps_done)
                parse_char(CH_NUL);
            if (step_out.size() > 0)
                step_out[step_out.size() - 1].run_end = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------- text building

    function automatic void add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void add_blanks(input int lo, input int hi);
        int n;
        n = $urandom_range(hi, lo);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0:       text_q.push_back(CH_TAB);
                1:       text_q.push_back(CH_LF);
                2:       text_q.push_back(CH_CR);
                default: text_q.push_back(CH_SP);
            endcase
        end
    endfunction

    function automatic logic [7:0] pick_quote();
        return $urandom_range(0, 1) ? CH_SQ : CH_DQ;
    endfunction

    function automatic void add_attr_head(input string kw);
        add_blanks(1, 2);
        add_str(kw);
        add_blanks(0, 1);
        text_q.push_back(CH_EQ);
        add_blanks(0, 1);
    endfunction

    // Mostly well-formed declarations with random content; some mutated, some noise
    function automatic void build_text(input bit rich);
        logic [7:0] q;
        int         n;
        int         pos;
        text_q.delete();
        if (!rich && $urandom_range(0, 99) < 12) begin
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++)
                text_q.push_back(KW_OPEN[i]);
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        add_str(KW_OPEN);
        add_blanks(1, 2);
        add_str(KW_VERSION);
        add_blanks(0, 1);
        text_q.push_back(CH_EQ);
        add_blanks(0, 1);
        q = pick_quote();
        text_q.push_back(q);
        add_str(KW_ONE);
        text_q.push_back(q);
        if (rich || $urandom_range(0, 99) < 60) begin
            add_attr_head(KW_ENCODING);
            q = pick_quote();
            text_q.push_back(q);
            n = rich ? 30 : $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) < 7)
                    text_q.push_back(NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)]);
                else
                    text_q.push_back(8'($urandom_range(1, 255)));
            end
            text_q.push_back(q);
        end
        if ($urandom_range(0, 1)) begin
            add_attr_head(KW_STANDALONE);
            q = pick_quote();
            text_q.push_back(q);
            add_str($urandom_range(0, 1) ? KW_YES : KW_NO);
            text_q.push_back(q);
        end
        add_blanks(0, 2);
        text_q.push_back(CH_QM);
        text_q.push_back(CH_GT);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++)
            text_q.push_back(8'($urandom_range(0, 255)));
        if (rich || $urandom_range(0, 99) >= 30)
            return;
        // break the sequence in one or two places
        n = $urandom_range(1, 2);
        for (int k = 0; k < n; k++) begin
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 3))
                0: text_q[pos] = 8'($urandom_range(0, 255));
                1: while (text_q.size() > pos + 1) void'(text_q.pop_back());
                2: if (text_q.size() > 1) text_q.delete(pos);
                default: text_q.insert(pos, 8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // ---------------------------------------------------------------- driving

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Offer one byte and wait for the transfer; then record what it should cause
    task automatic send_byte(input logic [7:0] c, input bit first, input bit last,
                             input bit typed, input xdp_pkg::t_out typed_verdict);
        int            gap;
        xdp_pkg::t_out r;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= c;
        i_is_first  <= first;
        i_is_last   <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        decl_step(c, first, last);
        sent_bytes++;
        foreach (step_out[k]) begin
            r = step_out[k];
            if (typed && r.kind == xdp_pkg::KIND_VERDICT) begin
                r.status = typed_verdict.status;
                r.len    = typed_verdict.len;
                r.sa     = typed_verdict.sa;
                r.enc    = typed_verdict.enc;
            end
            pending_results.push_back(r);
        end
    endtask

    task automatic send_text(input bit first, input bit last, input bit typed,
                             input xdp_pkg::t_out typed_verdict);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], first && i == 0, last && i == text_q.size() - 1,
                      typed, typed_verdict);
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    xdp_pkg::t_out seen_item;
    xdp_pkg::t_out want_item;

    // Compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            seen_item.kind    = o_item_kind;
            seen_item.name    = o_name_byte;
            seen_item.status  = o_status;
            seen_item.len     = o_decl_length;
            seen_item.sa      = o_standalone_value;
            seen_item.enc     = o_encoding_present;
            seen_item.run_end = o_run_end;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: kind %0d name %02h status %0d len %0d",
                         $time, seen_item.kind, seen_item.name, seen_item.status,
                         seen_item.len);
            end else begin
                want_item = pending_results.pop_front();
                check_field("item_kind", want_item.kind, seen_item.kind);
                check_field("name_byte", want_item.name, seen_item.name);
                check_field("status", want_item.status, seen_item.status);
                check_field("decl_length", want_item.len, seen_item.len);
                check_field("standalone_value", $signed(want_item.sa),
                            $signed(seen_item.sa));
                check_field("encoding_present", want_item.enc, seen_item.enc);
                check_field("run_end", want_item.run_end, seen_item.run_end);
            end
        end
    end

    // ---------------------------------------------------------------- clock, limit

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL xml_declaration_parser_top");
            $finish;
        end
    end

    // ---------------------------------------------------------------- result side

    // Stall the result channel at random; hold one long stretch when asked
    initial begin
        int  hold_left;
        bit  squeeze_done;
        int  r;
        hold_left    = 0;
        squeeze_done = 1'b0;
        i_stall      = 1'b0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (squeeze_req && !squeeze_done) begin
                i_stall      <= 1'b1;
                hold_left    = SQUEEZE_LEN - 1;
                squeeze_done = 1'b1;
            end else if (quiet || r < 60) begin
                i_stall <= 1'b0;
            end else if (r < 93) begin
                i_stall   <= 1'b1;
                hold_left = $urandom_range(0, 2);
            end else begin
                i_stall   <= 1'b1;
                hold_left = $urandom_range(5, 40);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        xdp_pkg::t_out tv;
        int            n_texts;
        bit            first;
        bit            last;
        sent_bytes   = 0;
        quiet        = 1'b0;
        squeeze_req  = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data_byte  = '0;
        i_is_first   = 1'b0;
        i_is_last    = 1'b0;
        start_text();
        ps_phase = P_IDLE;
        ps_done  = 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed texts
        foreach (text_rows[k]) begin
            text_q.delete();
            add_str(text_rows[k].head);
            repeat (text_rows[k].pad) text_q.push_back(CH_SP);
            add_str(text_rows[k].tail);
            if (text_rows[k].zpos >= 0)
                text_q[text_rows[k].zpos] = CH_NUL;
            tv        = '0;
            tv.kind   = xdp_pkg::KIND_VERDICT;
            tv.status = text_rows[k].st;
            tv.len    = text_rows[k].len;
            tv.sa     = text_rows[k].sa;
            tv.enc    = text_rows[k].enc;
            quiet = (text_rows[k].pad > 1000);
            send_text(text_rows[k].first, text_rows[k].last, text_rows[k].typed, tv);
        end

        // Random texts until the total byte count is reached
        n_texts = 0;
        tv      = '0;
        while (sent_bytes < ITEM_COUNT) begin
            quiet = ($urandom_range(0, 9) == 0);
            if (n_texts == 5) begin
                // long name while the result side holds off: fills the block
                squeeze_req = 1'b1;
                quiet       = 1'b1;
                build_text(1'b1);
            end else begin
                build_text(1'b0);
            end
            first = ($urandom_range(0, 99) >= 3);
            last  = ($urandom_range(0, 99) < 75);
            send_text(first, last, 1'b0, tv);
            n_texts++;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        quiet   = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("PASS xml_declaration_parser_top");
        else
            $display("FAIL xml_declaration_parser_top");
        $finish;
    end

endmodule
